### hdl/sparse_triplet_matrix_multiply_macros.svh
// ----------------------------------------------------------------------------
// sparse triplet matrix multiply - assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_MATRIX_MULTIPLY_MACROS_SVH
`define SPARSE_TRIPLET_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define STMM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stmm_pkg.sv
// ----------------------------------------------------------------------------
// stmm_pkg
// shared types, codes and fixed field widths of the sparse triplet multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package stmm_pkg;

  localparam int REQ_BITS       = 2;
  localparam int COORD_BITS     = 8;
  localparam int IN_VALUE_BITS  = 16;
  localparam int STATUS_BITS    = 3;
  localparam int OUT_VALUE_BITS = 32;

  localparam logic [REQ_BITS-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_MULT   = 2'd2;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_ACCEPT  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_PRODUCT = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NONE    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [REQ_BITS-1:0]             req_type;
    logic [COORD_BITS-1:0]           row_index;
    logic [COORD_BITS-1:0]           col_index;
    logic signed [IN_VALUE_BITS-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]           status;
    logic [COORD_BITS-1:0]            out_row;
    logic [COORD_BITS-1:0]            out_col;
    logic signed [OUT_VALUE_BITS-1:0] out_value;
    logic                             last;
  } out_item_t;

  typedef struct packed {
    logic                   load_a;
    logic                   load_b;
    logic                   clear;
    logic                   scan_start;
    logic                   scan_step;
    logic                   push_simple;
    logic [STATUS_BITS-1:0] simple_code;
    logic                   push_pend;
    logic                   pend_last;
  } dp_cmd_t;

  typedef struct packed {
    logic a_full;
    logic b_full;
    logic any_empty;
    logic match;
    logic pend_valid;
    logic last_pair;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/stmm_if.sv
// ----------------------------------------------------------------------------
// stmm channel interfaces
// valid/ready channels for input items, results and the config write
// ----------------------------------------------------------------------------
`default_nettype none

interface stmm_in_if
  import stmm_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stmm_out_if
  import stmm_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stmm_cfg_if ();
  logic valid;
  logic ready;
  logic transpose_a;

  modport source (output valid, output transpose_a, input ready);
  modport sink (input valid, input transpose_a, output ready);
endinterface

`default_nettype wire

### hdl/stmm_ram.sv
// ----------------------------------------------------------------------------
// stmm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module stmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/stmm_ctrl.sv
// ----------------------------------------------------------------------------
// stmm_ctrl
// request decode and scan sequencing for the sparse triplet multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module stmm_ctrl
  import stmm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [REQ_BITS-1:0] in_req,
  output logic                     in_ready,
  input  wire dp_sts_t             sts,
  output dp_cmd_t                  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req)
            REQ_LOAD_A: begin
              cmd.push_simple = 1'b1;
              if (sts.a_full) begin
                cmd.simple_code = ST_FULL;
              end else begin
                cmd.load_a      = 1'b1;
                cmd.simple_code = ST_ACCEPT;
              end
            end
            REQ_LOAD_B: begin
              cmd.push_simple = 1'b1;
              if (sts.b_full) begin
                cmd.simple_code = ST_FULL;
              end else begin
                cmd.load_b      = 1'b1;
                cmd.simple_code = ST_ACCEPT;
              end
            end
            REQ_CLEAR: begin
              cmd.clear       = 1'b1;
              cmd.push_simple = 1'b1;
              cmd.simple_code = ST_CLEARED;
            end
            REQ_MULT: begin
              if (sts.any_empty) begin
                cmd.push_simple = 1'b1;
                cmd.simple_code = ST_NONE;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // a second match waits while the output register is still full
        if (!(sts.match && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_step = 1'b1;
          if (sts.match && sts.pend_valid) begin
            cmd.push_pend = 1'b1;
            cmd.pend_last = 1'b0;
          end
          if (sts.last_pair) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.push_pend = 1'b1;
            cmd.pend_last = 1'b1;
          end else begin
            cmd.push_simple = 1'b1;
            cmd.simple_code = ST_NONE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/stmm_dp.sv
// ----------------------------------------------------------------------------
// stmm_dp
// triplet stores, pair pointers, multiplier, pending term and output register
// ----------------------------------------------------------------------------
`default_nettype none

module stmm_dp
  import stmm_pkg::*;
#(
  parameter int ENTRY_DEPTH = 8,
  parameter int INDEX_BITS  = 8,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dp_cmd_t   cmd,
  output dp_sts_t        sts,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_valid,
  input  wire logic      cfg_transpose,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int ADDR_BITS  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(ENTRY_DEPTH + 1);
  localparam int ENTRY_BITS = 2 * INDEX_BITS + VALUE_BITS;
  localparam int PROD_BITS  = 2 * VALUE_BITS;

  logic                  transpose_r;
  logic [CNT_BITS-1:0]   a_count_r;
  logic [CNT_BITS-1:0]   b_count_r;
  logic [ADDR_BITS-1:0]  i_r;
  logic [ADDR_BITS-1:0]  i_nxt;
  logic [ADDR_BITS-1:0]  j_r;
  logic [ADDR_BITS-1:0]  j_nxt;
  logic                  i_wrap;
  logic                  j_wrap;

  logic [INDEX_BITS-1:0] ld_row;
  logic [INDEX_BITS-1:0] ld_col;
  logic [VALUE_BITS-1:0] ld_val;
  logic [ENTRY_BITS-1:0] a_wdata;
  logic [ENTRY_BITS-1:0] b_wdata;
  logic [ENTRY_BITS-1:0] a_rdata;
  logic [ENTRY_BITS-1:0] b_rdata;

  logic [INDEX_BITS-1:0]        a_row;
  logic [INDEX_BITS-1:0]        a_col;
  logic signed [VALUE_BITS-1:0] a_val;
  logic [INDEX_BITS-1:0]        b_row;
  logic [INDEX_BITS-1:0]        b_col;
  logic signed [VALUE_BITS-1:0] b_val;
  logic signed [PROD_BITS-1:0]  prod;
  logic                         match;

  logic                             pend_valid_r;
  logic [INDEX_BITS-1:0]            pend_row_r;
  logic [INDEX_BITS-1:0]            pend_col_r;
  logic signed [OUT_VALUE_BITS-1:0] pend_value_r;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;

  // load data
  assign ld_row  = INDEX_BITS'(in_data.row_index);
  assign ld_col  = INDEX_BITS'(in_data.col_index);
  assign ld_val  = VALUE_BITS'($signed(in_data.entry_value));
  assign a_wdata = transpose_r ? {ld_col, ld_row, ld_val} : {ld_row, ld_col, ld_val};
  assign b_wdata = {ld_row, ld_col, ld_val};

  // pair pointers, the stores are read at the next pointer values so the registered read data lines up with the compare
  assign i_wrap = (CNT_BITS'(i_r) + CNT_BITS'(1)) == a_count_r;
  assign j_wrap = (CNT_BITS'(j_r) + CNT_BITS'(1)) == b_count_r;

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.scan_start) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.scan_step) begin
      if (j_wrap) begin
        i_nxt = ADDR_BITS'(i_r + ADDR_BITS'(1));
        j_nxt = '0;
      end else begin
        j_nxt = ADDR_BITS'(j_r + ADDR_BITS'(1));
      end
    end
  end

  stmm_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRY_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (cmd.load_a),
    .waddr (a_count_r[ADDR_BITS-1:0]),
    .wdata (a_wdata),
    .raddr (i_nxt),
    .rdata (a_rdata)
  );

  stmm_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRY_DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (cmd.load_b),
    .waddr (b_count_r[ADDR_BITS-1:0]),
    .wdata (b_wdata),
    .raddr (j_nxt),
    .rdata (b_rdata)
  );

  assign a_row = a_rdata[ENTRY_BITS-1 -: INDEX_BITS];
  assign a_col = a_rdata[VALUE_BITS +: INDEX_BITS];
  assign a_val = a_rdata[VALUE_BITS-1:0];
  assign b_row = b_rdata[ENTRY_BITS-1 -: INDEX_BITS];
  assign b_col = b_rdata[VALUE_BITS +: INDEX_BITS];
  assign b_val = b_rdata[VALUE_BITS-1:0];

  assign match = (a_col == b_row);
  assign prod  = a_val * b_val;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r  <= 1'b0;
      a_count_r    <= '0;
      b_count_r    <= '0;
      i_r          <= '0;
      j_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        transpose_r <= cfg_transpose;
      end
      if (cmd.clear) begin
        a_count_r <= '0;
        b_count_r <= '0;
      end
      if (cmd.load_a) begin
        a_count_r <= CNT_BITS'(a_count_r + CNT_BITS'(1));
      end
      if (cmd.load_b) begin
        b_count_r <= CNT_BITS'(b_count_r + CNT_BITS'(1));
      end
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (cmd.scan_start) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.scan_step && match) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.push_simple || cmd.push_pend) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && match) begin
      pend_row_r   <= a_row;
      pend_col_r   <= b_col;
      pend_value_r <= OUT_VALUE_BITS'(prod);
    end
    if (cmd.push_simple) begin
      out_data_r.status    <= cmd.simple_code;
      out_data_r.out_row   <= '0;
      out_data_r.out_col   <= '0;
      out_data_r.out_value <= '0;
      out_data_r.last      <= 1'b1;
    end else if (cmd.push_pend) begin
      out_data_r.status    <= ST_PRODUCT;
      out_data_r.out_row   <= COORD_BITS'(pend_row_r);
      out_data_r.out_col   <= COORD_BITS'(pend_col_r);
      out_data_r.out_value <= pend_value_r;
      out_data_r.last      <= cmd.pend_last;
    end
  end

  assign sts.a_full     = (a_count_r == CNT_BITS'(ENTRY_DEPTH));
  assign sts.b_full     = (b_count_r == CNT_BITS'(ENTRY_DEPTH));
  assign sts.any_empty  = (a_count_r == '0) || (b_count_r == '0);
  assign sts.match      = match;
  assign sts.pend_valid = pend_valid_r;
  assign sts.last_pair  = i_wrap && j_wrap;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/sparse_triplet_matrix_multiply.sv
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_multiply
// coordinate-triplet stores for matrices a and b with a pairwise multiply scan
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   req_type, row_index, col_index, entry_value
// out_ch   out  status, out_row, out_col, out_value, last
// cfg_ch   in   transpose_a
//
// load and clear: the single result is registered for the next cycle. multiply:
// a start step, then one a/b pair per cycle through the registered read ports
// of the two stores while the scan is not paused, then a finish step; with
// either store empty it answers with a single status result.
// a match is held back one term to mark last,
// so the scan pauses while a held term waits on a stalled output.
// reset is synchronous; counts, transpose_a and control clear, stores do not.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triplet_matrix_multiply
  import stmm_pkg::*;
#(
  parameter int ENTRY_DEPTH = 8,
  parameter int INDEX_BITS  = 8,
  parameter int VALUE_BITS  = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  stmm_in_if.sink    in_ch,
  stmm_out_if.source out_ch,
  stmm_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  stmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_req   (in_ch.data.req_type),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stmm_dp #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_ch.data),
    .cfg_valid     (cfg_ch.valid),
    .cfg_transpose (cfg_ch.transpose_a),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data)
  );

endmodule

`default_nettype wire

### hdl/stmm_checker.sv
// ----------------------------------------------------------------------------
// stmm_port_checker
// port-level checks of the sparse triplet multiplier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_triplet_matrix_multiply_macros.svh"

module stmm_port_checker
  import stmm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [REQ_BITS-1:0] in_req,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire out_item_t           out_data
);

  // stalled result holds
  `STMM_ASSERT_NEXT(a_out_hold,
    out_valid && !out_ready,
    out_valid && $stable(out_data),
    "stalled result changed")

  // load and clear answer in the next cycle
  `STMM_ASSERT_NEXT(a_single_reply,
    in_valid && in_ready && (in_req != REQ_MULT),
    out_valid,
    "no reply to load or clear")

  // no new transaction while a result is stuck
  `STMM_ASSERT_IMPL(a_ready_drained,
    in_ready,
    !out_valid || out_ready,
    "input taken over a blocked result")

  // non-product results carry zero fields and close the request
  `STMM_ASSERT_IMPL(a_plain_fields,
    out_valid && (out_data.status != ST_PRODUCT),
    out_data.last && (out_data.out_row == '0) && (out_data.out_col == '0)
      && (out_data.out_value == '0),
    "bad non-product result")

endmodule

bind sparse_triplet_matrix_multiply stmm_port_checker u_stmm_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_req    (in_ch.data.req_type),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

### test/stmm_checker.sv
// ----------------------------------------------------------------------------
// stmm_checker
// watches the request, result and config channels of the sparse triplet
// multiplier, keeps its own copy of both coordinate stores and of the
// transpose flag, predicts every result of each accepted request in order
// and compares each accepted result field by field against the oldest one
// ----------------------------------------------------------------------------
module stmm_checker
  import stmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_transpose,
  output int        mismatches,
  output int        outstanding,
  output int        results_checked
);

  localparam int DEPTH = 8;

  logic                            transpose_q;
  logic [COORD_BITS-1:0]           a_row [DEPTH];
  logic [COORD_BITS-1:0]           a_col [DEPTH];
  logic signed [IN_VALUE_BITS-1:0] a_val [DEPTH];
  logic [COORD_BITS-1:0]           b_row [DEPTH];
  logic [COORD_BITS-1:0]           b_col [DEPTH];
  logic signed [IN_VALUE_BITS-1:0] b_val [DEPTH];
  int                              a_fill;
  int                              b_fill;
  out_item_t                       expected_terms [$];
  out_item_t                       oldest;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    transpose_q     = 1'b0;
    a_fill          = 0;
    b_fill          = 0;
  end

  function automatic out_item_t status_result(input logic [STATUS_BITS-1:0] st);
    out_item_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // walks a outer, b inner; one term is held back so the final one gets last
  task automatic predict_request(input in_item_t req);
    out_item_t                        held;
    logic                             have_held;
    logic signed [OUT_VALUE_BITS-1:0] prod;
    have_held = 1'b0;
    held      = '0;
    case (req.req_type)
      REQ_LOAD_A: begin
        if (a_fill >= DEPTH) begin
          expected_terms.push_back(status_result(ST_FULL));
        end else begin
          if (transpose_q) begin
            a_row[a_fill] = req.col_index;
            a_col[a_fill] = req.row_index;
          end else begin
            a_row[a_fill] = req.row_index;
            a_col[a_fill] = req.col_index;
          end
          a_val[a_fill] = req.entry_value;
          a_fill++;
          expected_terms.push_back(status_result(ST_ACCEPT));
        end
      end
      REQ_LOAD_B: begin
        if (b_fill >= DEPTH) begin
          expected_terms.push_back(status_result(ST_FULL));
        end else begin
          b_row[b_fill] = req.row_index;
          b_col[b_fill] = req.col_index;
          b_val[b_fill] = req.entry_value;
          b_fill++;
          expected_terms.push_back(status_result(ST_ACCEPT));
        end
      end
      REQ_CLEAR: begin
        a_fill = 0;
        b_fill = 0;
        expected_terms.push_back(status_result(ST_CLEARED));
      end
      default: begin
        for (int i = 0; i < a_fill; i++) begin
          for (int j = 0; j < b_fill; j++) begin
            if (a_col[i] == b_row[j]) begin
              if (have_held) begin
                expected_terms.push_back(held);
              end
              prod           = a_val[i] * b_val[j];
              held           = '0;
              held.status    = ST_PRODUCT;
              held.out_row   = a_row[i];
              held.out_col   = b_col[j];
              held.out_value = prod;
              have_held      = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expected_terms.push_back(held);
        end else begin
          expected_terms.push_back(status_result(ST_NONE));
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      transpose_q = 1'b0;
      a_fill      = 0;
      b_fill      = 0;
      expected_terms.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_terms.size() == 0) begin
          $error("unexpected result: status %0d row %0d col %0d value %0d last %0d",
                 out_data.status, out_data.out_row, out_data.out_col,
                 out_data.out_value, out_data.last);
          mismatches++;
        end else begin
          oldest = expected_terms.pop_front();
          check_field("status", oldest.status, out_data.status);
          check_field("out_row", oldest.out_row, out_data.out_row);
          check_field("out_col", oldest.out_col, out_data.out_col);
          check_field("out_value", oldest.out_value, out_data.out_value);
          check_field("last", oldest.last, out_data.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        transpose_q = cfg_transpose;
      end
      if (in_valid && in_ready) begin
        predict_request(in_data);
      end
    end
    outstanding = expected_terms.size();
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the sparse triplet multiplier with a directed pass over the field
// extremes, full stores, empty and transposed multiplies, then with random
// load/multiply sequences under three pacing mixes and both transpose
// settings, including one long result stall; a checker grades every result
// ----------------------------------------------------------------------------
module tb;
  import stmm_pkg::*;

  localparam int LONG_STALL = 300;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   stall_requests = 0;
  int   stall_served   = 0;
  int   items_sent     = 0;
  logic cur_transpose;
  int   mismatches;
  int   outstanding;
  int   results_checked;

  stmm_in_if  in_ch ();
  stmm_out_if out_ch ();
  stmm_cfg_if cfg_ch ();

  sparse_triplet_matrix_multiply u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  stmm_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_transpose   (cfg_ch.transpose_a),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random backpressure, or one long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_served != stall_requests) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_served++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        @(negedge clk);
      end
    end
  end

  function automatic in_item_t make_item(input logic [REQ_BITS-1:0] req,
                                         input logic [COORD_BITS-1:0] r,
                                         input logic [COORD_BITS-1:0] c,
                                         input logic signed [IN_VALUE_BITS-1:0] v);
    in_item_t it;
    it.req_type    = req;
    it.row_index   = r;
    it.col_index   = c;
    it.entry_value = v;
    return it;
  endfunction

  function automatic logic signed [IN_VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // drops the request line and waits for every result, before a config write or the end
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_transpose(input logic t);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.transpose_a <= t;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_transpose = t;
  endtask

  // mostly clear / loads around a small set of join keys / multiply, some noise
  task automatic random_batch(input int count);
    int                    goal;
    int                    pool_n;
    int                    na;
    int                    nb;
    int                    k;
    logic [COORD_BITS-1:0] pool [4];
    logic [COORD_BITS-1:0] key;
    logic [COORD_BITS-1:0] other;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        send_request(make_item(REQ_BITS'($urandom), COORD_BITS'($urandom),
                               COORD_BITS'($urandom), IN_VALUE_BITS'($urandom)));
      end else begin
        pool_n = $urandom_range(1, 4);
        for (k = 0; k < 4; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            pool[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end else begin
            pool[k] = COORD_BITS'($urandom);
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          send_request(make_item(REQ_CLEAR, COORD_BITS'($urandom),
                                 COORD_BITS'($urandom), pick_value()));
        end
        na = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 5);
        nb = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 5);
        while (na > 0 || nb > 0) begin
          key   = ($urandom_range(0, 5) == 0) ? COORD_BITS'($urandom)
                                              : pool[$urandom_range(0, pool_n - 1)];
          other = COORD_BITS'($urandom);
          if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
            if (cur_transpose) begin
              send_request(make_item(REQ_LOAD_A, key, other, pick_value()));
            end else begin
              send_request(make_item(REQ_LOAD_A, other, key, pick_value()));
            end
            na--;
          end else begin
            send_request(make_item(REQ_LOAD_B, key, other, pick_value()));
            nb--;
          end
        end
        send_request(make_item(REQ_MULT, COORD_BITS'($urandom),
                               COORD_BITS'($urandom), pick_value()));
        if ($urandom_range(0, 2) == 0) begin
          key = pool[$urandom_range(0, pool_n - 1)];
          send_request(make_item(REQ_LOAD_B, key, COORD_BITS'($urandom), pick_value()));
          send_request(make_item(REQ_MULT, COORD_BITS'($urandom),
                                 COORD_BITS'($urandom), pick_value()));
        end
      end
    end
  endtask

  initial begin
    int k;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data         = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.transpose_a = 1'b0;
    cur_transpose      = 1'b0;
    tx_idle_pct        = 34;
    rx_idle_pct        = 66;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    write_transpose(1'b0);

    // empty stores, extreme coordinates and values, both stores filled past full
    send_request(make_item(REQ_MULT, 8'h00, 8'h00, 16'sh0000));
    send_request(make_item(REQ_LOAD_A, 8'h01, 8'hff, 16'sh8000));
    send_request(make_item(REQ_LOAD_B, 8'hff, 8'h00, 16'sh8000));
    send_request(make_item(REQ_LOAD_A, 8'hff, 8'h00, 16'sh7fff));
    send_request(make_item(REQ_LOAD_B, 8'h00, 8'hff, 16'sh7fff));
    send_request(make_item(REQ_LOAD_B, 8'hff, 8'haa, -16'sd1));
    send_request(make_item(REQ_MULT, 8'hff, 8'hff, 16'shffff));
    for (k = 0; k < 7; k++) begin
      send_request(make_item(REQ_LOAD_A, COORD_BITS'(k * 37 + 2), 8'h00, pick_value()));
    end
    for (k = 0; k < 6; k++) begin
      send_request(make_item(REQ_LOAD_B, 8'h00, COORD_BITS'($urandom), pick_value()));
    end
    send_request(make_item(REQ_MULT, 8'h00, 8'h00, 16'sh0000));
    send_request(make_item(REQ_CLEAR, 8'h00, 8'h00, 16'sh0000));
    send_request(make_item(REQ_MULT, 8'h00, 8'h00, 16'sh0000));

    // transposed a: a load at (3,5) joins b on row 3, not on row 5
    write_transpose(1'b1);
    send_request(make_item(REQ_LOAD_A, 8'd3, 8'd5, 16'sd100));
    send_request(make_item(REQ_LOAD_B, 8'd5, 8'd9, -16'sd7));
    send_request(make_item(REQ_MULT, 8'd0, 8'd0, 16'sd0));
    send_request(make_item(REQ_LOAD_B, 8'd3, 8'd9, -16'sd7));
    send_request(make_item(REQ_MULT, 8'd0, 8'd0, 16'sd0));

    random_batch(160);

    write_transpose(1'b0);
    tx_idle_pct = 66;
    rx_idle_pct = 34;
    random_batch(160);

    write_transpose(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_requests++;
    random_batch(160);

    drain_results();
    repeat (20) @(negedge clk);
    $display("run covered %0d requests over three pacing mixes, transpose on and off,",
             items_sent);
    $display("  full stores, empty multiplies and a long result stall; %0d results checked",
             results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
